/* hdl/rpp_pkg.sv */
// Shared types, constants and saturating arithmetic helpers for the particle pusher.
// All intermediates are 64-bit signed fixed point that saturates at +-(2^63-1).
// No dependencies.
package rpp_pkg;

  localparam int IW = 64;

  typedef logic signed [IW-1:0] fix_t;

  localparam fix_t IMAX = {1'b0, {(IW-1){1'b1}}};
  localparam fix_t IMIN = {1'b1, {(IW-1){1'b0}}};

  // Number of register stages in each of the arithmetic units.
  localparam int L_MUL  = 4;
  localparam int L_SQRT = 64;
  localparam int L_DIV  = 128;

  typedef enum logic [1:0] {
    REG_CMH  = 2'd0,
    REG_DT   = 2'd1,
    REG_DIMS = 2'd2
  } reg_idx_t;

  function automatic fix_t sadd(fix_t a, fix_t b);
    logic signed [IW:0] s;
    s = (IW+1)'(a) + (IW+1)'(b);
    if (s > (IW+1)'(IMAX)) begin
      return IMAX;
    end else if (s < -((IW+1)'(IMAX))) begin
      return -IMAX;
    end
    return s[IW-1:0];
  endfunction

  function automatic fix_t ssub(fix_t a, fix_t b);
    return sadd(a, -b);
  endfunction

  function automatic fix_t dbl(fix_t a);
    return sadd(a, a);
  endfunction

  // Clamp to a signed range of w bits.
  function automatic fix_t satw(fix_t x, int w);
    fix_t hi;
    hi = (fix_t'(1) <<< (w - 1)) - fix_t'(1);
    if (x > hi) begin
      return hi;
    end else if (x < -hi - fix_t'(1)) begin
      return -hi - fix_t'(1);
    end
    return x;
  endfunction

  // The most negative code is never used; it reads as its symmetric neighbor.
  function automatic fix_t fix_min(fix_t x);
    return (x == IMIN) ? -IMAX : x;
  endfunction

  function automatic fix_t at_least(fix_t x, fix_t lo);
    return (x < lo) ? lo : x;
  endfunction

  // Signed halving that truncates toward zero.
  function automatic fix_t half(fix_t x);
    fix_t t;
    t = x + fix_t'(x[IW-1]);
    return t >>> 1;
  endfunction

endpackage

/* hdl/rpp_pipe.sv */
// Delay line that keeps a value in step with the main pipeline.
// Depends on nothing but the clock enable of the pipeline.
module rpp_pipe #(
  parameter int W = 64,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d_i;
      for (int i = 1; i < N; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  assign q_o = sr_r[N-1];

endmodule

/* hdl/rpp_mul.sv */
// Pipelined signed fixed-point multiplier: round half away from zero, shift, saturate.
// Uses rpp_pkg; the 64x64 product is built from four 32x32 partial products.
module rpp_mul import rpp_pkg::*; #(
  parameter int SHIFT = 32
) (
  input  logic clk,
  input  logic en,
  input  fix_t a_i,
  input  fix_t b_i,
  output fix_t p_o
);

  localparam logic [2*IW-1:0] RND = ((2*IW)'(1) << SHIFT) >> 1;

  logic            neg1_r, neg2_r, neg3_r;
  logic [IW-1:0]   ua_r, ub_r;
  logic [IW-1:0]   p00_r, p01_r, p10_r, p11_r;
  logic [2*IW-1:0] sum_r;
  fix_t            p_r;
  logic [2*IW-1:0] shifted;
  logic [IW-1:0]   mag;

  always_comb begin
    shifted = sum_r >> SHIFT;
    mag     = (|shifted[2*IW-1:IW-1]) ? IMAX : shifted[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r <= a_i[IW-1] ^ b_i[IW-1];
      ua_r   <= a_i[IW-1] ? IW'(-a_i) : IW'(a_i);
      ub_r   <= b_i[IW-1] ? IW'(-b_i) : IW'(b_i);

      neg2_r <= neg1_r;
      p00_r  <= ua_r[31:0]  * ub_r[31:0];
      p01_r  <= ua_r[31:0]  * ub_r[63:32];
      p10_r  <= ua_r[63:32] * ub_r[31:0];
      p11_r  <= ua_r[63:32] * ub_r[63:32];

      neg3_r <= neg2_r;
      sum_r  <= {p11_r, {IW{1'b0}}} + ((2*IW)'(p01_r) << 32) + ((2*IW)'(p10_r) << 32)
                + (2*IW)'(p00_r) + RND;

      p_r    <= neg3_r ? -fix_t'(mag) : fix_t'(mag);
    end
  end

  assign p_o = p_r;

endmodule

/* hdl/rpp_sqrt.sv */
// Pipelined fixed-point square root, one result bit per stage, truncated.
// Uses rpp_pkg; a non-positive argument gives zero.
module rpp_sqrt import rpp_pkg::*; #(
  parameter int FRAC_BITS = 32
) (
  input  logic clk,
  input  logic en,
  input  fix_t x_i,
  output fix_t r_o
);

  logic [2*IW-1:0] n_r   [L_SQRT];
  logic [IW+2:0]   rem_r [L_SQRT];
  logic [IW-1:0]   q_r   [L_SQRT];
  logic [2*IW-1:0] n0;

  assign n0 = (x_i > fix_t'(0)) ? ((2*IW)'(IW'(x_i)) << FRAC_BITS) : '0;

  for (genvar i = 0; i < L_SQRT; i++) begin : g_step
    logic [2*IW-1:0] n_in;
    logic [IW+2:0]   rem_in, cur, trial;
    logic [IW-1:0]   q_in;

    if (i == 0) begin : g_first
      assign n_in   = n0;
      assign rem_in = '0;
      assign q_in   = '0;
    end else begin : g_next
      assign n_in   = n_r[i-1];
      assign rem_in = rem_r[i-1];
      assign q_in   = q_r[i-1];
    end

    assign cur   = {rem_in[IW:0], n_in[2*IW-1:2*IW-2]};
    assign trial = {1'b0, q_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[i] <= n_in << 2;
        if (cur >= trial) begin
          rem_r[i] <= cur - trial;
          q_r[i]   <= {q_in[IW-2:0], 1'b1};
        end else begin
          rem_r[i] <= cur;
          q_r[i]   <= {q_in[IW-2:0], 1'b0};
        end
      end
    end
  end

  assign r_o = q_r[L_SQRT-1][IW-1] ? IMAX : fix_t'(q_r[L_SQRT-1]);

endmodule

/* hdl/rpp_recip.sv */
// Pipelined fixed-point reciprocal by restoring division, one quotient bit per stage.
// Uses rpp_pkg; the argument is raised to at least one LSB, the result rounds to nearest.
module rpp_recip import rpp_pkg::*; #(
  parameter int FRAC_BITS = 32
) (
  input  logic clk,
  input  logic en,
  input  fix_t x_i,
  output fix_t r_o
);

  logic [2*IW-1:0] n_r   [L_DIV];
  logic [IW-1:0]   d_r   [L_DIV];
  logic [IW-1:0]   rem_r [L_DIV];
  logic [IW-2:0]   q_r   [L_DIV];
  logic            ovf_r [L_DIV];
  logic [IW-1:0]   ux;
  logic [2*IW-1:0] n0;

  assign ux = (x_i < fix_t'(1)) ? IW'(1) : IW'(x_i);
  assign n0 = ((2*IW)'(1) << (2 * FRAC_BITS)) + (2*IW)'(ux >> 1);

  for (genvar i = 0; i < L_DIV; i++) begin : g_step
    logic [2*IW-1:0] n_in;
    logic [IW-1:0]   d_in, rem_in;
    logic [IW-2:0]   q_in;
    logic            ovf_in, ge;
    logic [IW:0]     cur, diff;

    if (i == 0) begin : g_first
      assign n_in   = n0;
      assign d_in   = ux;
      assign rem_in = '0;
      assign q_in   = '0;
      assign ovf_in = 1'b0;
    end else begin : g_next
      assign n_in   = n_r[i-1];
      assign d_in   = d_r[i-1];
      assign rem_in = rem_r[i-1];
      assign q_in   = q_r[i-1];
      assign ovf_in = ovf_r[i-1];
    end

    assign cur  = {rem_in, n_in[2*IW-1]};
    assign ge   = cur >= {1'b0, d_in};
    assign diff = cur - {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[i]   <= n_in << 1;
        d_r[i]   <= d_in;
        rem_r[i] <= ge ? diff[IW-1:0] : cur[IW-1:0];
        q_r[i]   <= {q_in[IW-3:0], ge};
        // Quotient bits that leave the kept width force saturation.
        ovf_r[i] <= ovf_in | q_in[IW-2];
      end
    end
  end

  assign r_o = ovf_r[L_DIV-1] ? IMAX : fix_t'({1'b0, q_r[L_DIV-1]});

endmodule

/* hdl/relativistic_particle_push.sv */
// Relativistic particle pusher, top level: Higuera-Cary momentum update.
// Uses rpp_pkg, rpp_pipe, rpp_mul, rpp_sqrt and rpp_recip.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_stall  | charge, E, B, old momentum, last
//   out_    | output    | out_valid / out_stall| new momentum, inv_gamma, displacement, last
//   cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item enters per cycle while in_stall is low; results leave in the same order on out_.
// The latency is set by the chain of three square roots (64 stages each) and three
// reciprocals (128 stages each) on the critical data path.
// A single clock enable moves every stage; it drops only while a result waits under
// out_stall, and in_stall is its complement. Reset clears the valid bits and loads the
// configuration registers with their defaults.
module relativistic_particle_push import rpp_pkg::*; #(
  parameter int VALUE_WIDTH = 48,
  parameter int FRAC_BITS   = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [7:0]             in_charge_units,
  input  logic signed [VALUE_WIDTH-1:0] in_field_ex,
  input  logic signed [VALUE_WIDTH-1:0] in_field_ey,
  input  logic signed [VALUE_WIDTH-1:0] in_field_ez,
  input  logic signed [VALUE_WIDTH-1:0] in_field_bx,
  input  logic signed [VALUE_WIDTH-1:0] in_field_by,
  input  logic signed [VALUE_WIDTH-1:0] in_field_bz,
  input  logic signed [VALUE_WIDTH-1:0] in_mom_x_in,
  input  logic signed [VALUE_WIDTH-1:0] in_mom_y_in,
  input  logic signed [VALUE_WIDTH-1:0] in_mom_z_in,
  input  logic                          in_last_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [VALUE_WIDTH-1:0] out_mom_x_out,
  output logic signed [VALUE_WIDTH-1:0] out_mom_y_out,
  output logic signed [VALUE_WIDTH-1:0] out_mom_z_out,
  output logic        [FRAC_BITS:0]     out_inv_gamma,
  output logic signed [VALUE_WIDTH-1:0] out_disp_x,
  output logic signed [VALUE_WIDTH-1:0] out_disp_y,
  output logic signed [VALUE_WIDTH-1:0] out_disp_z,
  output logic                          out_last_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [VALUE_WIDTH-2:0]        cfg_data
);

  localparam int   M   = L_MUL;
  localparam fix_t ONE = fix_t'(1) <<< FRAC_BITS;

  // Times at which each value sits in a register, counted from the input stage.
  localparam int T_K    = M;
  localparam int T_H    = T_K + M;
  localparam int T_UM   = T_H + 1;
  localparam int T_P1   = T_UM + M;
  localparam int T_DOT1 = T_P1 + 1;
  localparam int T_D    = T_DOT1 + 1;
  localparam int T_P2   = T_D + M;
  localparam int T_X4   = T_P2 + 1;
  localparam int T_SA   = T_X4 + 1;
  localparam int T_SQ1  = T_SA + L_SQRT;
  localparam int T_G2   = T_SQ1 + 1;
  localparam int T_SQ2  = T_G2 + L_SQRT;
  localparam int T_IG   = T_SQ2 + L_DIV;
  localparam int T_TS   = T_IG + M;
  localparam int T_TT   = T_TS + M;
  localparam int T_MA   = T_TT + 1;
  localparam int T_MB   = T_MA + 1;
  localparam int T_IDET = T_MB + L_DIV;
  localparam int T_P3   = T_MB + M;
  localparam int T_DOT3 = T_P3 + 1;
  localparam int T_NR   = T_IDET + M;
  localparam int T_N    = T_NR + 1;
  localparam int T_P4   = T_N + M;
  localparam int T_DOT4 = T_P4 + 1;
  localparam int T_ARG  = T_DOT4 + 1;
  localparam int T_SQ3  = T_ARG + L_SQRT;
  localparam int T_IGO  = T_SQ3 + L_DIV;
  localparam int T_DISP = T_IGO + M;
  localparam int T_OUT  = T_DISP + 1;

  logic en;

  // Configuration registers.
  logic [VALUE_WIDTH-2:0] cmh_r, dt_r;
  logic [1:0]             dims_r;
  fix_t                   cmh_x, dt_x;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmh_r  <= (VALUE_WIDTH-1)'(64'd1 << (FRAC_BITS - 1));
      dt_r   <= (VALUE_WIDTH-1)'(64'd1 << FRAC_BITS);
      dims_r <= 2'd3;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CMH:  cmh_r  <= cfg_data;
        REG_DT:   dt_r   <= cfg_data;
        REG_DIMS: dims_r <= cfg_data[1:0];
        default:  ;
      endcase
    end
  end

  assign cmh_x = IW'(cmh_r);
  assign dt_x  = IW'(dt_r);

  // Valid bits travel with the data; index 0 is the input stage.
  logic [T_OUT:0] vld_r;

  assign en       = !(vld_r[T_OUT] && out_stall);
  assign in_stall = !en;
  assign out_valid = vld_r[T_OUT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[T_OUT-1:0], in_valid};
    end
  end

  // Input stage.
  fix_t chg_r;
  fix_t e_r [3];
  fix_t b_r [3];
  fix_t m_r [3];
  logic last_r;

  always_ff @(posedge clk) begin
    if (en) begin
      chg_r  <= IW'(in_charge_units);
      e_r[0] <= fix_min(IW'(in_field_ex));
      e_r[1] <= fix_min(IW'(in_field_ey));
      e_r[2] <= fix_min(IW'(in_field_ez));
      b_r[0] <= fix_min(IW'(in_field_bx));
      b_r[1] <= fix_min(IW'(in_field_by));
      b_r[2] <= fix_min(IW'(in_field_bz));
      m_r[0] <= fix_min(IW'(in_mom_x_in));
      m_r[1] <= fix_min(IW'(in_mom_y_in));
      m_r[2] <= fix_min(IW'(in_mom_z_in));
      last_r <= in_last_in;
    end
  end

  // Charge scale factor.
  fix_t k;
  rpp_mul #(.SHIFT(0)) u_mul_k (.clk, .en, .a_i(chg_r), .b_i(cmh_x), .p_o(k));

  fix_t e_d [3], b_d [3], m_d [3];
  fix_t h [3], tb [3], tb_u [3], tb_g [3], h_d [3];
  fix_t um_r [3], um_d [3];
  fix_t uu [3], tt [3], tu [3];

  for (genvar i = 0; i < 3; i++) begin : g_kick
    rpp_pipe #(.W(IW), .N(T_K)) u_e (.clk, .en, .d_i(e_r[i]), .q_o(e_d[i]));
    rpp_pipe #(.W(IW), .N(T_K)) u_b (.clk, .en, .d_i(b_r[i]), .q_o(b_d[i]));
    rpp_pipe #(.W(IW), .N(T_H)) u_m (.clk, .en, .d_i(m_r[i]), .q_o(m_d[i]));
    rpp_mul #(.SHIFT(FRAC_BITS)) u_h (.clk, .en, .a_i(k), .b_i(e_d[i]), .p_o(h[i]));
    rpp_mul #(.SHIFT(FRAC_BITS)) u_t (.clk, .en, .a_i(k), .b_i(b_d[i]), .p_o(tb[i]));
    rpp_pipe #(.W(IW), .N(T_UM - T_H)) u_tu (.clk, .en, .d_i(tb[i]), .q_o(tb_u[i]));
    rpp_pipe #(.W(IW), .N(T_IG - T_H)) u_tg (.clk, .en, .d_i(tb[i]), .q_o(tb_g[i]));
    rpp_pipe #(.W(IW), .N(T_NR - T_H)) u_hd (.clk, .en, .d_i(h[i]), .q_o(h_d[i]));

    always_ff @(posedge clk) begin
      if (en) begin
        um_r[i] <= sadd(m_d[i], h[i]);
      end
    end

    rpp_pipe #(.W(IW), .N(T_MB - T_UM)) u_umd (.clk, .en, .d_i(um_r[i]), .q_o(um_d[i]));
    rpp_mul #(.SHIFT(FRAC_BITS)) u_uu (.clk, .en, .a_i(um_r[i]), .b_i(um_r[i]), .p_o(uu[i]));
    rpp_mul #(.SHIFT(FRAC_BITS)) u_tt (.clk, .en, .a_i(tb_u[i]), .b_i(tb_u[i]), .p_o(tt[i]));
    rpp_mul #(.SHIFT(FRAC_BITS)) u_tum (.clk, .en, .a_i(tb_u[i]), .b_i(um_r[i]), .p_o(tu[i]));
  end

  // Mid-step gamma from the quadratic in gamma squared.
  fix_t uu_s_r, tt_s_r, tu_s_r, d_r, w_r, beta_d, ww, dd, x4_r, dd_r, sarg_r;
  fix_t sq1, d_d, g2_r, sq2, ig;

  always_ff @(posedge clk) begin
    if (en) begin
      uu_s_r <= sadd(uu[0], sadd(uu[1], uu[2]));
      tt_s_r <= sadd(tt[0], sadd(tt[1], tt[2]));
      tu_s_r <= sadd(tu[0], sadd(tu[1], tu[2]));
      d_r    <= ssub(sadd(ONE, uu_s_r), tt_s_r);
      w_r    <= tu_s_r;
      x4_r   <= dbl(dbl(sadd(beta_d, ww)));
      dd_r   <= dd;
      sarg_r <= sadd(dd_r, x4_r);
      g2_r   <= at_least(half(sadd(d_d, sq1)), ONE);
    end
  end

  rpp_pipe #(.W(IW), .N(T_P2 - T_DOT1)) u_beta (.clk, .en, .d_i(tt_s_r), .q_o(beta_d));
  rpp_mul #(.SHIFT(FRAC_BITS)) u_ww (.clk, .en, .a_i(w_r), .b_i(w_r), .p_o(ww));
  rpp_mul #(.SHIFT(FRAC_BITS)) u_dd (.clk, .en, .a_i(d_r), .b_i(d_r), .p_o(dd));
  rpp_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sq1 (.clk, .en, .x_i(sarg_r), .r_o(sq1));
  rpp_pipe #(.W(IW), .N(T_SQ1 - T_D)) u_dd_d (.clk, .en, .d_i(d_r), .q_o(d_d));
  rpp_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sq2 (.clk, .en, .x_i(g2_r), .r_o(sq2));
  rpp_recip #(.FRAC_BITS(FRAC_BITS)) u_rc1 (.clk, .en, .x_i(sq2), .r_o(ig));

  // Rotation matrix from the scaled magnetic vector.
  fix_t ts [3], ts_d [3];
  fix_t txx, tyy, tzz, txy, tyz, tzx;

  for (genvar i = 0; i < 3; i++) begin : g_scale
    rpp_mul #(.SHIFT(FRAC_BITS)) u_ts (.clk, .en, .a_i(tb_g[i]), .b_i(ig), .p_o(ts[i]));
    rpp_pipe #(.W(IW), .N(T_TT - T_TS)) u_tsd (.clk, .en, .d_i(ts[i]), .q_o(ts_d[i]));
  end

  rpp_mul #(.SHIFT(FRAC_BITS)) u_txx (.clk, .en, .a_i(ts[0]), .b_i(ts[0]), .p_o(txx));
  rpp_mul #(.SHIFT(FRAC_BITS)) u_tyy (.clk, .en, .a_i(ts[1]), .b_i(ts[1]), .p_o(tyy));
  rpp_mul #(.SHIFT(FRAC_BITS)) u_tzz (.clk, .en, .a_i(ts[2]), .b_i(ts[2]), .p_o(tzz));
  rpp_mul #(.SHIFT(FRAC_BITS)) u_txy (.clk, .en, .a_i(ts[0]), .b_i(ts[1]), .p_o(txy));
  rpp_mul #(.SHIFT(FRAC_BITS)) u_tyz (.clk, .en, .a_i(ts[1]), .b_i(ts[2]), .p_o(tyz));
  rpp_mul #(.SHIFT(FRAC_BITS)) u_tzx (.clk, .en, .a_i(ts[2]), .b_i(ts[0]), .p_o(tzx));

  fix_t a00_r, a11_r, a22_r, zz_r, q_r, den_r, idet;
  fix_t m01_r, m02_r, m10_r, m12_r, m20_r, m21_r;
  fix_t mat_r [3][3];

  always_ff @(posedge clk) begin
    if (en) begin
      a00_r <= ssub(sadd(ONE, txx), tyy);
      a11_r <= sadd(ssub(ONE, txx), tyy);
      a22_r <= ssub(ssub(ONE, txx), tyy);
      zz_r  <= tzz;
      q_r   <= sadd(txx, sadd(tyy, tzz));
      m01_r <= dbl(sadd(txy, ts_d[2]));
      m02_r <= dbl(ssub(tzx, ts_d[1]));
      m10_r <= dbl(ssub(txy, ts_d[2]));
      m12_r <= dbl(sadd(tyz, ts_d[0]));
      m20_r <= dbl(sadd(tzx, ts_d[1]));
      m21_r <= dbl(ssub(tyz, ts_d[0]));

      mat_r[0][0] <= ssub(a00_r, zz_r);
      mat_r[0][1] <= m01_r;
      mat_r[0][2] <= m02_r;
      mat_r[1][0] <= m10_r;
      mat_r[1][1] <= ssub(a11_r, zz_r);
      mat_r[1][2] <= m12_r;
      mat_r[2][0] <= m20_r;
      mat_r[2][1] <= m21_r;
      mat_r[2][2] <= sadd(a22_r, zz_r);
      den_r       <= sadd(ONE, q_r);
    end
  end

  rpp_recip #(.FRAC_BITS(FRAC_BITS)) u_rc2 (.clk, .en, .x_i(den_r), .r_o(idet));

  // Rotated momentum, second half kick, then the new Lorentz factor and the displacement.
  fix_t pr [3][3];
  fix_t nd_r [3], nd_d [3], nr [3], n_r [3], nn [3], dtn [3], dtn_d [3], n_dd [3], ds [3];
  fix_t n2_r, arg_r, sq3, igo, igo_d;
  logic last_d;

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      rpp_mul #(.SHIFT(FRAC_BITS)) u_pr (
        .clk, .en, .a_i(mat_r[r][c]), .b_i(um_d[c]), .p_o(pr[r][c])
      );
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nd_r[r] <= sadd(pr[r][0], sadd(pr[r][1], pr[r][2]));
        n_r[r]  <= satw(sadd(h_d[r], nr[r]), VALUE_WIDTH);
      end
    end

    rpp_pipe #(.W(IW), .N(T_IDET - T_DOT3)) u_ndd (.clk, .en, .d_i(nd_r[r]), .q_o(nd_d[r]));
    rpp_mul #(.SHIFT(FRAC_BITS)) u_nr (.clk, .en, .a_i(nd_d[r]), .b_i(idet), .p_o(nr[r]));
    rpp_mul #(.SHIFT(FRAC_BITS)) u_nn (.clk, .en, .a_i(n_r[r]), .b_i(n_r[r]), .p_o(nn[r]));
    rpp_mul #(.SHIFT(FRAC_BITS)) u_dtn (.clk, .en, .a_i(dt_x), .b_i(n_r[r]), .p_o(dtn[r]));
    rpp_pipe #(.W(IW), .N(T_IGO - T_P4)) u_dtnd (.clk, .en, .d_i(dtn[r]), .q_o(dtn_d[r]));
    rpp_pipe #(.W(IW), .N(T_DISP - T_N)) u_nd2 (.clk, .en, .d_i(n_r[r]), .q_o(n_dd[r]));
    rpp_mul #(.SHIFT(FRAC_BITS)) u_ds (.clk, .en, .a_i(dtn_d[r]), .b_i(igo), .p_o(ds[r]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n2_r  <= sadd(nn[0], sadd(nn[1], nn[2]));
      arg_r <= at_least(sadd(ONE, n2_r), ONE);
    end
  end

  rpp_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sq3 (.clk, .en, .x_i(arg_r), .r_o(sq3));
  rpp_recip #(.FRAC_BITS(FRAC_BITS)) u_rc3 (.clk, .en, .x_i(sq3), .r_o(igo));
  rpp_pipe #(.W(IW), .N(T_DISP - T_IGO)) u_igod (.clk, .en, .d_i(igo), .q_o(igo_d));
  rpp_pipe #(.W(1), .N(T_DISP)) u_last (.clk, .en, .d_i(last_r), .q_o(last_d));

  // Output register.
  fix_t ds_sat [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      ds_sat[r] = satw(ds[r], VALUE_WIDTH);
    end
  end

  logic signed [VALUE_WIDTH-1:0] mom_r [3];
  logic signed [VALUE_WIDTH-1:0] disp_r [3];
  logic        [FRAC_BITS:0]     ig_out_r;
  logic                          last_out_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        mom_r[r] <= n_dd[r][VALUE_WIDTH-1:0];
      end
      disp_r[0]  <= ds_sat[0][VALUE_WIDTH-1:0];
      disp_r[1]  <= (dims_r >= 2'd2) ? ds_sat[1][VALUE_WIDTH-1:0] : '0;
      disp_r[2]  <= (dims_r == 2'd3) ? ds_sat[2][VALUE_WIDTH-1:0] : '0;
      ig_out_r   <= igo_d[FRAC_BITS:0];
      last_out_r <= last_d;
    end
  end

  assign out_mom_x_out = mom_r[0];
  assign out_mom_y_out = mom_r[1];
  assign out_mom_z_out = mom_r[2];
  assign out_disp_x    = disp_r[0];
  assign out_disp_y    = disp_r[1];
  assign out_disp_z    = disp_r[2];
  assign out_inv_gamma = ig_out_r;
  assign out_last_out  = last_out_r;

endmodule

/* hdl/rpp_chk.sv */
// Port-level checker for the particle pusher, bound to the top level.
// Sees only the ports of relativistic_particle_push.
module rpp_chk #(
  parameter int VALUE_WIDTH = 48,
  parameter int FRAC_BITS   = 32
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [VALUE_WIDTH-1:0] out_mom_x_out,
  input logic        [FRAC_BITS:0]     out_inv_gamma,
  input logic                          out_last_out
);

  localparam logic [FRAC_BITS:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_mom_x_out) && $stable(out_last_out))
    else $error("stalled result changed");

  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow the output side");

  a_gamma: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_inv_gamma <= ONE_Q)
    else $error("inverse gamma above one");

endmodule

bind relativistic_particle_push rpp_chk #(
  .VALUE_WIDTH(VALUE_WIDTH),
  .FRAC_BITS(FRAC_BITS)
) u_rpp_chk (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_mom_x_out(out_mom_x_out),
  .out_inv_gamma(out_inv_gamma),
  .out_last_out(out_last_out)
);

/* verif/relativistic_particle_push_tb.sv */
// Self-checking testbench for relativistic_particle_push: directed and random particles
// are checked against a bit-exact fixed-point predictor of the Higuera-Cary push.
// Depends on rpp_pkg and the relativistic_particle_push RTL.
module relativistic_particle_push_tb;
  import rpp_pkg::*;

  localparam int VW = 48;
  localparam int FB = 32;
  localparam logic [1:0] CFG_IDX_UNUSED = 2'd3;
  localparam int LONG_HOLD = 900;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 700;

  typedef longint signed fx_t;
  localparam fx_t FX_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam fx_t FX_ONE = 64'sd1 <<< FB;

  typedef struct {
    logic signed [7:0] charge;
    logic signed [VW-1:0] ex, ey, ez, bx, by, bz, px, py, pz;
    logic last;
  } particle_t;

  typedef struct {
    logic signed [VW-1:0] px, py, pz;
    logic [FB:0] inv_gamma;
    logic signed [VW-1:0] dx, dy, dz;
    logic last;
  } push_result_t;

  class push_scoreboard;
    logic [VW-2:0] cmh, dt;
    logic [1:0] dims;
    int errors;
    push_result_t expected_q[$];

    function new();
      cmh = 47'd1 << (FB - 1);
      dt = 47'd1 << FB;
      dims = 2'd3;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [VW-2:0] data);
      case (idx)
        REG_CMH: cmh = data;
        REG_DT: dt = data;
        REG_DIMS: dims = data[1:0];
        default: ;
      endcase
    endfunction

    function fx_t sat_add(fx_t a, fx_t b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > FX_MAX) return FX_MAX;
      if (s < -FX_MAX) return -FX_MAX;
      return s[63:0];
    endfunction

    function fx_t sat_sub(fx_t a, fx_t b);
      return sat_add(a, -b);
    endfunction

    function fx_t twice(fx_t a);
      return sat_add(a, a);
    endfunction

    function fx_t clamp_vw(fx_t x);
      fx_t hi;
      hi = (64'sd1 <<< (VW - 1)) - 1;
      if (x > hi) return hi;
      if (x < -hi - 1) return -hi - 1;
      return x;
    endfunction

    // Product shifted right by sh, rounded half away from zero, saturated.
    function fx_t mul_round(fx_t a, fx_t b, int sh);
      logic neg;
      logic [63:0] ua, ub;
      logic [127:0] p;
      fx_t mag;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? 64'(-a) : 64'(a);
      ub = (b < 0) ? 64'(-b) : 64'(b);
      p = {64'd0, ua} * {64'd0, ub};
      if (sh > 0) p = (p + (128'd1 << (sh - 1))) >> sh;
      mag = (p > 128'(FX_MAX)) ? FX_MAX : fx_t'(p[63:0]);
      return neg ? -mag : mag;
    endfunction

    function fx_t fmul(fx_t a, fx_t b);
      return mul_round(a, b, FB);
    endfunction

    function fx_t dot(fx_t a0, fx_t a1, fx_t a2, fx_t b0, fx_t b1, fx_t b2);
      return sat_add(fmul(a0, b0), sat_add(fmul(a1, b1), fmul(a2, b2)));
    endfunction

    function fx_t fix_sqrt(fx_t x);
      logic [127:0] n;
      logic [63:0] r, c;
      if (x <= 0) return 0;
      n = {64'd0, x} << FB;
      r = 0;
      for (int b = 63; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if ({64'd0, c} * {64'd0, c} <= n) r = c;
      end
      return (r > 64'(FX_MAX)) ? FX_MAX : fx_t'(r);
    endfunction

    function fx_t fix_recip(fx_t x);
      logic [63:0] ux;
      logic [127:0] q;
      ux = (x < 1) ? 64'd1 : 64'(x);
      q = ((128'd1 << (2 * FB)) + {64'd0, ux >> 1}) / {64'd0, ux};
      return (q > 128'(FX_MAX)) ? FX_MAX : fx_t'(q[63:0]);
    endfunction

    function fx_t fix_rsqrt(fx_t x);
      return fix_recip(fix_sqrt((x < FX_ONE) ? FX_ONE : x));
    endfunction

    function push_result_t push_particle(particle_t p);
      push_result_t r;
      fx_t k, hx, hy, hz, tx, ty, tz, ux, uy, uz, gm2, beta2, w, d, x4, g2, ig;
      fx_t txx, tyy, tzz, txy, tyz, tzx, idet, nx, ny, nz, igo, t;
      k = mul_round(fx_t'(p.charge), fx_t'({17'd0, cmh}), 0);
      hx = fmul(k, p.ex); hy = fmul(k, p.ey); hz = fmul(k, p.ez);
      tx = fmul(k, p.bx); ty = fmul(k, p.by); tz = fmul(k, p.bz);
      ux = sat_add(p.px, hx); uy = sat_add(p.py, hy); uz = sat_add(p.pz, hz);
      gm2 = sat_add(FX_ONE, dot(ux, uy, uz, ux, uy, uz));
      beta2 = dot(tx, ty, tz, tx, ty, tz);
      w = dot(tx, ty, tz, ux, uy, uz);
      d = sat_sub(gm2, beta2);
      x4 = twice(twice(sat_add(beta2, fmul(w, w))));
      g2 = sat_add(d, fix_sqrt(sat_add(fmul(d, d), x4))) / 2;
      ig = fix_rsqrt(g2);
      tx = fmul(tx, ig); ty = fmul(ty, ig); tz = fmul(tz, ig);
      txx = fmul(tx, tx); tyy = fmul(ty, ty); tzz = fmul(tz, tz);
      txy = fmul(tx, ty); tyz = fmul(ty, tz); tzx = fmul(tz, tx);
      idet = fix_recip(sat_add(FX_ONE, sat_add(txx, sat_add(tyy, tzz))));
      nx = fmul(dot(sat_sub(sat_sub(sat_add(FX_ONE, txx), tyy), tzz),
                    twice(sat_add(txy, tz)), twice(sat_sub(tzx, ty)), ux, uy, uz), idet);
      ny = fmul(dot(twice(sat_sub(txy, tz)),
                    sat_sub(sat_add(sat_sub(FX_ONE, txx), tyy), tzz),
                    twice(sat_add(tyz, tx)), ux, uy, uz), idet);
      nz = fmul(dot(twice(sat_add(tzx, ty)), twice(sat_sub(tyz, tx)),
                    sat_add(sat_sub(sat_sub(FX_ONE, txx), tyy), tzz), ux, uy, uz), idet);
      nx = clamp_vw(sat_add(hx, nx));
      ny = clamp_vw(sat_add(hy, ny));
      nz = clamp_vw(sat_add(hz, nz));
      igo = fix_rsqrt(sat_add(FX_ONE, dot(nx, ny, nz, nx, ny, nz)));
      t = fx_t'({17'd0, dt});
      r.px = nx[VW-1:0]; r.py = ny[VW-1:0]; r.pz = nz[VW-1:0];
      r.inv_gamma = igo[FB:0];
      r.dx = VW'(clamp_vw(fmul(fmul(t, nx), igo)));
      r.dy = (dims >= 2) ? VW'(clamp_vw(fmul(fmul(t, ny), igo))) : '0;
      r.dz = (dims >= 3) ? VW'(clamp_vw(fmul(fmul(t, nz), igo))) : '0;
      r.last = p.last;
      return r;
    endfunction

    function void note_item(particle_t p);
      expected_q.push_back(push_particle(p));
    endfunction

    function void compare(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(push_result_t r);
      push_result_t e;
      if (expected_q.size() == 0) begin
        $error("result item arrived with no particle outstanding");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      compare("mom_x_out", 64'(e.px), 64'(r.px));
      compare("mom_y_out", 64'(e.py), 64'(r.py));
      compare("mom_z_out", 64'(e.pz), 64'(r.pz));
      compare("inv_gamma", 64'(e.inv_gamma), 64'(r.inv_gamma));
      compare("disp_x", 64'(e.dx), 64'(r.dx));
      compare("disp_y", 64'(e.dy), 64'(r.dy));
      compare("disp_z", 64'(e.dz), 64'(r.dz));
      compare("last_out", 64'(e.last), 64'(r.last));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  particle_t drv = '{default: '0};
  logic out_valid;
  logic out_stall = 1'b1;
  push_result_t mon;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [VW-2:0] cfg_data = '0;

  logic hold_req = 1'b0;
  logic quiet_phase = 1'b0;
  int quiet_cycles = 0;
  push_scoreboard sb = new();

  always #4 clk = ~clk;

  relativistic_particle_push dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_charge_units(drv.charge),
    .in_field_ex(drv.ex), .in_field_ey(drv.ey), .in_field_ez(drv.ez),
    .in_field_bx(drv.bx), .in_field_by(drv.by), .in_field_bz(drv.bz),
    .in_mom_x_in(drv.px), .in_mom_y_in(drv.py), .in_mom_z_in(drv.pz),
    .in_last_in(drv.last),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_mom_x_out(mon.px), .out_mom_y_out(mon.py), .out_mom_z_out(mon.pz),
    .out_inv_gamma(mon.inv_gamma),
    .out_disp_x(mon.dx), .out_disp_y(mon.dy), .out_disp_z(mon.dz),
    .out_last_out(mon.last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(mon);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("relativistic_particle_push test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stall bursts, one long hold on request, none at the end.
  initial begin
    int len;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
      end else if (quiet_phase) begin
        out_stall = 1'b0;
      end else begin
        len = $urandom_range(1, 12);
        out_stall = ($urandom_range(0, 3) == 0);
        if (!out_stall) len = $urandom_range(1, 30);
        repeat (len - 1) @(negedge clk);
      end
    end
  end

  function automatic logic signed [VW-1:0] rand_value(int mode);
    logic signed [VW-1:0] v;
    v = VW'({$urandom, $urandom});
    case (mode)
      0: return v;
      1: return v >>> $urandom_range(8, 46);
      2: return {1'b0, {(VW-1){1'b1}}};
      3: return {1'b1, {(VW-1){1'b0}}};
      default: return '0;
    endcase
  endfunction

  function automatic particle_t rand_particle();
    particle_t p;
    int m;
    m = $urandom_range(0, 9);
    // Mostly physically sized particles, with some full-range and extreme ones.
    p.charge = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8) - 4);
    p.ex = rand_value(m < 7 ? 1 : $urandom_range(0, 4));
    p.ey = rand_value(m < 7 ? 1 : $urandom_range(0, 4));
    p.ez = rand_value(m < 7 ? 1 : $urandom_range(0, 4));
    p.bx = rand_value(m < 7 ? 1 : $urandom_range(0, 4));
    p.by = rand_value(m < 7 ? 1 : $urandom_range(0, 4));
    p.bz = rand_value(m < 7 ? 1 : $urandom_range(0, 4));
    p.px = rand_value(m < 7 ? 1 : $urandom_range(0, 4));
    p.py = rand_value(m < 7 ? 1 : $urandom_range(0, 4));
    p.pz = rand_value(m < 7 ? 1 : $urandom_range(0, 4));
    p.last = 1'($urandom_range(0, 1));
    return p;
  endfunction

  task automatic send_particle(particle_t p);
    if (!quiet_phase && !hold_req && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid = 1'b1;
    drv = p;
    do @(posedge clk); while (in_stall);
    sb.note_item(p);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [VW-2:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic run_phase(logic [VW-2:0] cmh, logic [VW-2:0] dt, logic [1:0] dims, int n);
    wait_drained();
    write_reg(REG_CMH, cmh);
    write_reg(REG_DT, dt);
    write_reg(REG_DIMS, dims);
    repeat (n) send_particle(rand_particle());
  endtask

  initial begin
    particle_t p;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed items at the reset register values.
    p = '{default: '0};
    send_particle(p);
    p.last = 1'b1;
    send_particle(p);
    p = '{charge: 8'sd127, ex: rand_value(2), ey: rand_value(3), ez: rand_value(2),
          bx: rand_value(2), by: rand_value(3), bz: rand_value(2),
          px: rand_value(2), py: rand_value(3), pz: rand_value(2), last: 1'b0};
    send_particle(p);
    p.charge = -8'sd128;
    send_particle(p);
    p.ex = rand_value(3); p.ey = rand_value(2); p.ez = rand_value(3);
    p.bx = rand_value(3); p.by = rand_value(2); p.bz = rand_value(3);
    p.px = rand_value(3); p.py = rand_value(2); p.pz = rand_value(3);
    send_particle(p);
    // Strong magnetic field on a slow particle pulls the mid-step gamma toward one.
    p = '{default: '0};
    p.charge = 8'sd1;
    p.bz = 48'sd1 <<< 40;
    p.px = 48'sd1 <<< 20;
    send_particle(p);
    p.bx = -(48'sd1 <<< 38); p.by = 48'sd1 <<< 39;
    send_particle(p);
    // Huge electric field saturates the new momentum.
    p = '{default: '0};
    p.charge = 8'sd100;
    p.ex = rand_value(2); p.ey = rand_value(3); p.ez = 48'sd1 <<< 45;
    send_particle(p);
    // Zero charge passes the momentum through a pure drift.
    p = rand_particle();
    p.charge = '0;
    send_particle(p);
    repeat (12) send_particle(rand_particle());
    // Pause until every result is back, then go on.
    wait_drained();
    repeat (240) send_particle(rand_particle());

    run_phase({(VW-1){1'b1}}, '0, 2'd1, 120);
    run_phase('0, {(VW-1){1'b1}}, 2'd2, 120);
    run_phase(47'd1 << 28, 47'd1 << 32, 2'd0, 150);

    // Result side holds off while particles keep coming, so the pipeline fills up.
    wait_drained();
    write_reg(REG_CMH, 47'd1 << 31);
    write_reg(REG_DT, 47'd1 << 30);
    write_reg(REG_DIMS, 2'd3);
    hold_req = 1'b1;
    repeat (800) send_particle(rand_particle());

    wait_drained();
    write_reg(CFG_IDX_UNUSED, {(VW-1){1'b1}});
    quiet_phase = 1'b1;
    run_phase(47'd1 << 33, 47'd1 << 32, 2'd2, 260);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("relativistic_particle_push test passed");
    end else begin
      $display("relativistic_particle_push test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/rpp_pkg.sv
hdl/rpp_pipe.sv
hdl/rpp_mul.sv
hdl/rpp_sqrt.sv
hdl/rpp_recip.sv
hdl/relativistic_particle_push.sv
hdl/rpp_chk.sv
verif/relativistic_particle_push_tb.sv
